[src/snz_pkg.sv]
// Shared types, codes and constants of the 2D simplex noise unit.
`default_nettype none
package snz_pkg;

  // Fixed field widths
  localparam int COORD_W = 32;
  localparam int CFG_W   = 16;
  localparam int BYTE_W  = 8;
  localparam int NOISE_W = 16;
  // Internal datapath widths, wide enough for any coordinate format in range
  localparam int LAT_W   = 36;  // lattice fractional parts and unskew term
  localparam int OFS_W   = 38;  // corner offsets
  localparam int TERM_W  = 32;  // one corner contribution
  localparam int SUM_W   = 34;  // sum of three contributions
  localparam int SCALE_W = 24;

  typedef enum logic {
    FUNC_EVAL  = 1'b0,
    FUNC_WRITE = 1'b1
  } func_e;

  typedef enum logic {
    CFG_SKEW   = 1'b0,
    CFG_UNSKEW = 1'b1
  } cfg_idx_e;

  localparam logic [CFG_W-1:0] SKEW_RESET   = 16'd23988;
  localparam logic [CFG_W-1:0] UNSKEW_RESET = 16'd13849;

  // 45.23065 in Q.16
  localparam logic signed [SCALE_W-1:0] NOISE_SCALE = 24'sd2964236;

  typedef struct packed {
    logic                      func;
    logic signed [COORD_W-1:0] x_coord;
    logic signed [COORD_W-1:0] y_coord;
    logic [BYTE_W-1:0]         table_index;
    logic [BYTE_W-1:0]         table_value;
  } in_item_t;

  typedef struct packed {
    logic signed [NOISE_W-1:0] noise_value;
  } out_item_t;

  // Lattice front end to corner lanes
  typedef struct packed {
    logic                    valid;
    logic signed [OFS_W-1:0] x0;
    logic signed [OFS_W-1:0] y0;
    logic signed [OFS_W-1:0] x1;
    logic signed [OFS_W-1:0] y1;
    logic signed [OFS_W-1:0] x2;
    logic signed [OFS_W-1:0] y2;
    logic [2:0]              h0;
    logic [2:0]              h1;
    logic [2:0]              h2;
  } lat_out_t;

endpackage
`default_nettype wire

[src/snz_stream_if.sv]
// Valid/ready stream interface with a typed payload.
`default_nettype none
interface snz_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[src/snz_ram.sv]
// Generic single write port RAM with one registered read port.
`default_nettype none
module snz_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule
`default_nettype wire

[src/snz_lattice.sv]
// Skew, cell floor, corner offsets and two-level permutation hash (five stages).
`default_nettype none
module snz_lattice
  import snz_pkg::*;
#(
  parameter int TABLE_SIZE      = 256,
  parameter int COORD_FRAC_BITS = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic             vld_i,
  input  wire in_item_t         item_i,
  input  wire logic [CFG_W-1:0] skew_i,
  input  wire logic [CFG_W-1:0] unskew_i,
  output lat_out_t              lat_o
);
  localparam int F     = COORD_FRAC_BITS;
  localparam int AW    = $clog2(TABLE_SIZE);  // table size is a power of two
  localparam int IW    = 35 - F;               // cell index width
  localparam int RAW_W = IW + 18;
  localparam int SH    = (F >= 16) ? F - 16 : 16 - F;
  localparam int G_W   = CFG_W + 9;
  localparam logic signed [OFS_W-1:0] ONE = OFS_W'(1) <<< F;

  // ---------------- stage 1: skew product
  logic signed [COORD_W:0]   xy_sum;
  logic signed [49:0]        prod1_d, prod1_q;
  logic                      v1_q, w1_q;
  logic signed [COORD_W-1:0] x1_q, y1_q;
  logic [BYTE_W-1:0]         idx1_q, val1_q;

  assign xy_sum  = (COORD_W+1)'(item_i.x_coord) + (COORD_W+1)'(item_i.y_coord);
  assign prod1_d = xy_sum * $signed({1'b0, skew_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      w1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= vld_i;
      w1_q <= (item_i.func == FUNC_WRITE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod1_q <= prod1_d;
      x1_q    <= item_i.x_coord;
      y1_q    <= item_i.y_coord;
      idx1_q  <= item_i.table_index;
      val1_q  <= item_i.table_value;
    end
  end

  // ---------------- stage 2: cell floor, first hash level read
  logic signed [33:0]  s2;
  logic signed [34:0]  xs2, ys2;
  logic signed [IW-1:0] i2_d, j2_d, i2_q, j2_q;
  logic [AW-1:0]       ja0, ja1, widx1;
  logic [BYTE_W-1:0]   pa0, pa1;
  logic                we_a;
  logic                v2_q, w2_q;
  logic signed [COORD_W-1:0] x2_q, y2_q;
  logic [BYTE_W-1:0]   idx2_q, val2_q;

  assign s2    = 34'(prod1_q >>> 16);
  assign xs2   = 35'(x1_q) + 35'(s2);
  assign ys2   = 35'(y1_q) + 35'(s2);
  assign i2_d  = IW'(xs2 >>> F);
  assign j2_d  = IW'(ys2 >>> F);
  assign ja0   = AW'(j2_d);
  assign ja1   = ja0 + AW'(1);
  assign widx1 = AW'({{AW{1'b0}}, idx1_q});
  assign we_a  = en_i & v1_q & w1_q;

  snz_ram #(.WIDTH(BYTE_W), .DEPTH(TABLE_SIZE)) u_ram_a0 (
    .clk_i, .we_i(we_a), .waddr_i(widx1), .wdata_i(val1_q),
    .re_i(en_i), .raddr_i(ja0), .rdata_o(pa0)
  );
  snz_ram #(.WIDTH(BYTE_W), .DEPTH(TABLE_SIZE)) u_ram_a1 (
    .clk_i, .we_i(we_a), .waddr_i(widx1), .wdata_i(val1_q),
    .re_i(en_i), .raddr_i(ja1), .rdata_o(pa1)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      w2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
      w2_q <= w1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      i2_q   <= i2_d;
      j2_q   <= j2_d;
      x2_q   <= x1_q;
      y2_q   <= y1_q;
      idx2_q <= idx1_q;
      val2_q <= val1_q;
    end
  end

  // ---------------- stage 3: unskew product, fractional parts
  logic signed [IW:0]      ij3;
  logic signed [RAW_W-1:0] raw3_d, raw3_q;
  logic signed [LAT_W-1:0] xr3_d, yr3_d, xr3_q, yr3_q;
  logic [AW-1:0]           il3_q;
  logic [BYTE_W-1:0]       pj0_3_q, pj1_3_q, idx3_q, val3_q;
  logic                    v3_q, w3_q;

  assign ij3    = (IW+1)'(i2_q) + (IW+1)'(j2_q);
  assign raw3_d = ij3 * $signed({1'b0, unskew_i});
  assign xr3_d  = LAT_W'(x2_q) - (LAT_W'(i2_q) <<< F);
  assign yr3_d  = LAT_W'(y2_q) - (LAT_W'(j2_q) <<< F);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      w3_q <= 1'b0;
    end else if (en_i) begin
      v3_q <= v2_q;
      w3_q <= w2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      raw3_q  <= raw3_d;
      xr3_q   <= xr3_d;
      yr3_q   <= yr3_d;
      il3_q   <= AW'(i2_q);
      pj0_3_q <= pa0;
      pj1_3_q <= pa1;
      idx3_q  <= idx2_q;
      val3_q  <= val2_q;
    end
  end

  // ---------------- stage 4: corner 0 offset and middle corner pick
  logic signed [LAT_W-1:0] t4;
  logic signed [OFS_W-1:0] x0_4, y0_4, x0_q, y0_q;
  logic                    i1_q;
  logic [AW-1:0]           il4_q;
  logic [BYTE_W-1:0]       pj0_4_q, pj1_4_q, idx4_q, val4_q;
  logic                    v4_q, w4_q;

  // Q.16 to coordinate format, floor when narrowing
  assign t4   = (F >= 16) ? (LAT_W'(raw3_q) <<< SH) : LAT_W'(raw3_q >>> SH);
  assign x0_4 = OFS_W'(xr3_q) + OFS_W'(t4);
  assign y0_4 = OFS_W'(yr3_q) + OFS_W'(t4);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      w4_q <= 1'b0;
    end else if (en_i) begin
      v4_q <= v3_q;
      w4_q <= w3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x0_q    <= x0_4;
      y0_q    <= y0_4;
      i1_q    <= (x0_4 > y0_4);
      il4_q   <= il3_q;
      pj0_4_q <= pj0_3_q;
      pj1_4_q <= pj1_3_q;
      idx4_q  <= idx3_q;
      val4_q  <= val3_q;
    end
  end

  // ---------------- stage 5: other offsets, second hash level read
  logic [G_W-1:0]          gq;
  logic signed [OFS_W-1:0] g5;
  logic signed [OFS_W-1:0] x1_5, y1_5, x2_5, y2_5;
  logic signed [OFS_W-1:0] x0_5_q, y0_5_q, x1_5_q, y1_5_q, x2_5_q, y2_5_q;
  logic [AW-1:0]           hb0, hb1, hb2, widx4;
  logic [BYTE_W-1:0]       pb0, pb1, pb2;
  logic                    we_b, v5_q;

  assign gq    = (F >= 16) ? (G_W'(unskew_i) << SH) : G_W'(unskew_i >> SH);
  assign g5    = $signed(OFS_W'(gq));
  assign x1_5  = x0_q - (i1_q ? ONE : '0) + g5;
  assign y1_5  = y0_q - (i1_q ? '0 : ONE) + g5;
  assign x2_5  = x0_q - ONE + (g5 <<< 1);
  assign y2_5  = y0_q - ONE + (g5 <<< 1);

  assign hb0   = il4_q + AW'({{AW{1'b0}}, pj0_4_q});
  assign hb1   = il4_q + AW'(i1_q) + AW'({{AW{1'b0}}, (i1_q ? pj0_4_q : pj1_4_q)});
  assign hb2   = il4_q + AW'(1) + AW'({{AW{1'b0}}, pj1_4_q});
  assign widx4 = AW'({{AW{1'b0}}, idx4_q});
  assign we_b  = en_i & v4_q & w4_q;

  snz_ram #(.WIDTH(BYTE_W), .DEPTH(TABLE_SIZE)) u_ram_b0 (
    .clk_i, .we_i(we_b), .waddr_i(widx4), .wdata_i(val4_q),
    .re_i(en_i), .raddr_i(hb0), .rdata_o(pb0)
  );
  snz_ram #(.WIDTH(BYTE_W), .DEPTH(TABLE_SIZE)) u_ram_b1 (
    .clk_i, .we_i(we_b), .waddr_i(widx4), .wdata_i(val4_q),
    .re_i(en_i), .raddr_i(hb1), .rdata_o(pb1)
  );
  snz_ram #(.WIDTH(BYTE_W), .DEPTH(TABLE_SIZE)) u_ram_b2 (
    .clk_i, .we_i(we_b), .waddr_i(widx4), .wdata_i(val4_q),
    .re_i(en_i), .raddr_i(hb2), .rdata_o(pb2)
  );

  // table writes stop here; only evaluations go on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (en_i) begin
      v5_q <= v4_q & ~w4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x0_5_q <= x0_q;
      y0_5_q <= y0_q;
      x1_5_q <= x1_5;
      y1_5_q <= y1_5;
      x2_5_q <= x2_5;
      y2_5_q <= y2_5;
    end
  end

  always_comb begin
    lat_o.valid = v5_q;
    lat_o.x0    = x0_5_q;
    lat_o.y0    = y0_5_q;
    lat_o.x1    = x1_5_q;
    lat_o.y1    = y1_5_q;
    lat_o.x2    = x2_5_q;
    lat_o.y2    = y2_5_q;
    lat_o.h0    = pb0[2:0];
    lat_o.h1    = pb1[2:0];
    lat_o.h2    = pb2[2:0];
  end
endmodule
`default_nettype wire

[src/snz_corner.sv]
// One corner lane: falloff, its fourth power and gradient product (five stages).
`default_nettype none
module snz_corner
  import snz_pkg::*;
#(
  parameter int COORD_FRAC_BITS = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic signed [OFS_W-1:0]  dx_i,
  input  wire logic signed [OFS_W-1:0]  dy_i,
  input  wire logic [2:0]               h_i,
  output logic signed      [TERM_W-1:0] term_o
);
  localparam int F   = COORD_FRAC_BITS;
  localparam int SQ_W = 2 * F + 2;
  localparam int D_W = 2 * F + 3;
  localparam int G_W = F + 3;
  localparam int P_W = F + 36;
  localparam int SH2 = (2 * F >= 32) ? 2 * F - 32 : 32 - 2 * F;
  localparam logic signed [OFS_W-1:0] ONE  = OFS_W'(1) <<< F;
  localparam logic signed [D_W-1:0]   HALF = D_W'(1) <<< (2 * F - 1);

  // ---------------- c1: range check, squares, gradient dot
  logic                   inr;
  logic signed [F:0]      dxs, dys, u1, v1;
  logic signed [G_W-1:0]  uu, vv, gval1;
  logic signed [SQ_W-1:0] dx2_q, dy2_q;
  logic signed [G_W-1:0]  gval1_q;
  logic                   live1_q;

  assign inr   = (dx_i > -ONE) && (dx_i < ONE) && (dy_i > -ONE) && (dy_i < ONE);
  assign dxs   = (F+1)'(dx_i);
  assign dys   = (F+1)'(dy_i);
  assign u1    = h_i[2] ? dys : dxs;
  assign v1    = h_i[2] ? dxs : dys;
  assign uu    = G_W'(u1);
  assign vv    = G_W'(v1) <<< 1;
  assign gval1 = (h_i[0] ? -uu : uu) + (h_i[1] ? -vv : vv);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      live1_q <= inr;
      dx2_q   <= dxs * dxs;
      dy2_q   <= dys * dys;
      gval1_q <= gval1;
    end
  end

  // ---------------- c2: falloff moved to Q.32
  logic signed [D_W-1:0]  d2;
  logic [31:0]            tq2, tq_q;
  logic signed [G_W-1:0]  gval2_q;
  logic                   live2_q;

  assign d2  = HALF - D_W'(dx2_q) - D_W'(dy2_q);
  assign tq2 = (2 * F >= 32) ? 32'(d2 >>> SH2) : (32'(d2) << SH2);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      live2_q <= live1_q && (d2 > 0);
      tq_q    <= tq2;
      gval2_q <= gval1_q;
    end
  end

  // ---------------- c3: square
  logic [63:0]           sq3;
  logic [31:0]           t2_q;
  logic signed [G_W-1:0] gval3_q;
  logic                  live3_q;

  assign sq3 = tq_q * tq_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      live3_q <= live2_q;
      t2_q    <= sq3[63:32];
      gval3_q <= gval2_q;
    end
  end

  // ---------------- c4: fourth power
  logic [63:0]           sq4;
  logic [31:0]           t4_q;
  logic signed [G_W-1:0] gval4_q;
  logic                  live4_q;

  assign sq4 = t2_q * t2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      live4_q <= live3_q;
      t4_q    <= sq4[63:32];
      gval4_q <= gval3_q;
    end
  end

  // ---------------- c5: weighted gradient, floor to Q.30
  logic signed [P_W-1:0]    p5;
  logic signed [TERM_W-1:0] term_q;

  assign p5 = $signed({1'b0, t4_q}) * gval4_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      term_q <= live4_q ? TERM_W'(p5 >>> (F + 2)) : '0;
    end
  end

  assign term_o = term_q;
endmodule
`default_nettype wire

[src/simplex_noise_2d_unit.sv]
// Top level of the 2D simplex noise unit: config, lanes, scaling and output register.
//
//  channel  | dir | handshake      | payload
//  ---------+-----+----------------+---------------------------------------------
//  in_i     | in  | valid/ready    | func, x_coord, y_coord, table_index, value
//  out_o    | out | valid/ready    | noise_value (signed Q1.14, saturated)
//  cfg      | in  | cfg_we_i       | cfg_idx_i, cfg_data_i
//
//  One item per cycle unless stalled; from transfer, an evaluation passes
//  five lattice/hash stages, five corner stages, sum, scale and output register.
//  A table write takes effect on each table copy as it passes that copy's read
//  stage, so items see the table in transfer order; it yields no result.
//  The whole pipeline stalls together while the output register holds an
//  untaken result. Reset clears valid bits and config; the table is not cleared.
`default_nettype none
module simplex_noise_2d_unit
  import snz_pkg::*;
#(
  parameter int TABLE_SIZE      = 256,
  parameter int COORD_FRAC_BITS = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  snz_stream_if.sink            in_i,
  snz_stream_if.source          out_o,
  input  wire logic             cfg_we_i,
  input  wire logic             cfg_idx_i,
  input  wire logic [CFG_W-1:0] cfg_data_i
);
  localparam int PROD_W = SUM_W + SCALE_W;
  localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1) <<< 31;
  localparam logic signed [PROD_W-1:0] SAT_HI   = PROD_W'(32767);
  localparam logic signed [PROD_W-1:0] SAT_LO   = -PROD_W'(32768);

  // configuration registers
  logic [CFG_W-1:0] skew_q, unskew_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skew_q   <= SKEW_RESET;
      unskew_q <= UNSKEW_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_SKEW:   skew_q   <= cfg_data_i;
        CFG_UNSKEW: unskew_q <= cfg_data_i;
      endcase
    end
  end

  // global advance
  logic en;
  logic out_vld_q;
  in_item_t item;

  assign en         = ~out_vld_q | out_o.ready;
  assign in_i.ready = en;
  assign item       = in_i.data;

  // lattice front end
  lat_out_t lat;

  snz_lattice #(.TABLE_SIZE(TABLE_SIZE), .COORD_FRAC_BITS(COORD_FRAC_BITS)) u_lattice (
    .clk_i, .rst_ni, .en_i(en), .vld_i(in_i.valid), .item_i(item),
    .skew_i(skew_q), .unskew_i(unskew_q), .lat_o(lat)
  );

  // three corner lanes
  logic signed [TERM_W-1:0] term0, term1, term2;

  snz_corner #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_corner0 (
    .clk_i, .en_i(en), .dx_i(lat.x0), .dy_i(lat.y0), .h_i(lat.h0), .term_o(term0)
  );
  snz_corner #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_corner1 (
    .clk_i, .en_i(en), .dx_i(lat.x1), .dy_i(lat.y1), .h_i(lat.h1), .term_o(term1)
  );
  snz_corner #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_corner2 (
    .clk_i, .en_i(en), .dx_i(lat.x2), .dy_i(lat.y2), .h_i(lat.h2), .term_o(term2)
  );

  // valid bits matching the corner lane depth
  logic [4:0] cv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q <= '0;
    end else if (en) begin
      cv_q <= {cv_q[3:0], lat.valid};
    end
  end

  // sum, then scale
  logic                     sv_q, pv_q;
  logic signed [SUM_W-1:0]  sum_q;
  logic signed [PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q <= 1'b0;
      pv_q <= 1'b0;
    end else if (en) begin
      sv_q <= cv_q[4];
      pv_q <= sv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sum_q  <= SUM_W'(term0) + SUM_W'(term1) + SUM_W'(term2);
      prod_q <= sum_q * NOISE_SCALE;
    end
  end

  // round half up to Q1.14 and saturate into the output register
  logic signed [PROD_W-1:0]  rnd;
  logic signed [NOISE_W-1:0] noise_d, noise_q;

  assign rnd = (prod_q + RND_HALF) >>> 32;

  always_comb begin
    priority if (rnd > SAT_HI) begin
      noise_d = NOISE_W'(SAT_HI);
    end else if (rnd < SAT_LO) begin
      noise_d = NOISE_W'(SAT_LO);
    end else begin
      noise_d = NOISE_W'(rnd);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= pv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      noise_q <= noise_d;
    end
  end

  assign out_o.valid            = out_vld_q;
  assign out_o.data.noise_value = noise_q;

  // checks
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_o.ready |=> out_vld_q && $stable(noise_q))
    else $error("output result changed while stalled");

  a_scale_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && pv_q |=> out_vld_q)
    else $error("scaled result did not reach output register");

  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(cv_q) && $stable(sv_q) && $stable(pv_q))
    else $error("pipeline moved during stall");
endmodule
`default_nettype wire

[dv/tb_simplex_noise_2d_unit.sv]
// Self-checking testbench for the 2D simplex noise unit: queued driver, checking monitor.
`default_nettype none
module tb_simplex_noise_2d_unit;
  import snz_pkg::*;

  localparam int DRAIN_CYCLES = 20;      // pipeline is 13 deep
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_ITEMS  = 250;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we;
  logic             cfg_idx;
  logic [CFG_W-1:0] cfg_data;

  snz_stream_if #(.payload_t(in_item_t))  in_if ();
  snz_stream_if #(.payload_t(out_item_t)) out_if ();

  simplex_noise_2d_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // Predictor state: register shadows and table image
  logic [CFG_W-1:0]  skew_shadow;
  logic [CFG_W-1:0]  unskew_shadow;
  logic [BYTE_W-1:0] perm_image [256];

  in_item_t                  pending_items [$];
  logic signed [NOISE_W-1:0] noise_expected [$];

  int  errors;
  int  evals_sent;
  int  writes_sent;
  int  results_seen;
  int  cycle_count;
  int  tx_idle_pct;
  int  rx_stall_pct;
  int  rx_hold_left;
  bit  rx_hold_req;
  bit  in_taken;

  always #5 clk_i = ~clk_i;

  // One corner contribution, floored to Q.30
  function automatic longint corner_term(longint dx, longint dy, logic [2:0] h);
    longint one;
    longint d;
    longint t2;
    longint t4;
    longint u;
    longint v;
    longint gval;
    one = 64'sd1 << 16;
    if (dx <= -one || dx >= one || dy <= -one || dy >= one) return 0;
    d = (64'sd1 << 31) - dx * dx - dy * dy;
    if (d <= 0) return 0;
    t2 = (d * d) >>> 32;
    t4 = (t2 * t2) >>> 32;
    u = h[2] ? dy : dx;
    v = h[2] ? dx : dy;
    gval = (h[0] ? -u : u) + (h[1] ? -2 * v : 2 * v);
    return (t4 * gval) >>> 18;
  endfunction

  function automatic logic [BYTE_W-1:0] perm_at(longint idx);
    return perm_image[idx & 255];
  endfunction

  // Expected noise sample for one point under the current registers and table
  function automatic logic signed [NOISE_W-1:0] noise_at(logic signed [31:0] xc,
                                                         logic signed [31:0] yc);
    longint x, y, s, i, j, t, g, x0, y0, x1, y1, x2, y2, i1, j1, sum, r;
    x = xc;
    y = yc;
    s = ((x + y) * longint'(skew_shadow)) >>> 16;
    i = (x + s) >>> 16;
    j = (y + s) >>> 16;
    t = (i + j) * longint'(unskew_shadow);
    g = longint'(unskew_shadow);
    x0 = x - (i <<< 16) + t;
    y0 = y - (j <<< 16) + t;
    // middle corner goes along x only when x0 is strictly larger
    i1 = (x0 > y0) ? 1 : 0;
    j1 = 1 - i1;
    x1 = x0 - (i1 <<< 16) + g;
    y1 = y0 - (j1 <<< 16) + g;
    x2 = x0 - (64'sd1 <<< 16) + 2 * g;
    y2 = y0 - (64'sd1 <<< 16) + 2 * g;
    sum = corner_term(x0, y0, perm_at(i + perm_at(j)))
        + corner_term(x1, y1, perm_at(i + i1 + perm_at(j + j1)))
        + corner_term(x2, y2, perm_at(i + 1 + perm_at(j + 1)));
    r = (sum * 2964236 + (64'sd1 <<< 31)) >>> 32;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  task automatic queue_eval(logic [31:0] xc, logic [31:0] yc);
    in_item_t it;
    it = '0;
    it.func = FUNC_EVAL;
    it.x_coord = xc;
    it.y_coord = yc;
    it.table_index = 8'($urandom);
    it.table_value = 8'($urandom);
    pending_items.push_back(it);
  endtask

  task automatic queue_write(logic [7:0] idx, logic [7:0] val);
    in_item_t it;
    it = '0;
    it.func = FUNC_WRITE;
    it.x_coord = $urandom;
    it.y_coord = $urandom;
    it.table_index = idx;
    it.table_value = val;
    pending_items.push_back(it);
  endtask

  // Random coordinate: mostly near the origin, sometimes anywhere
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 9))
      0, 1:    return $urandom;
      2:       return $urandom_range(0, 131071) - 65536;
      default: return $urandom_range(0, 2 * (256 << 16)) - (256 << 16);
    endcase
  endfunction

  task automatic queue_random(int n);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 19) == 0) queue_write(8'($urandom), 8'($urandom));
      else queue_eval(rand_coord(), rand_coord());
    end
  endtask

  // Wait for all items and results, then let the pipeline empty
  task automatic drain();
    wait (pending_items.size() == 0 && !in_if.valid && noise_expected.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_cfg(cfg_idx_e idx, logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    if (idx == CFG_SKEW) skew_shadow = val;
    else unskew_shadow = val;
  endtask

  // Driver: new item after a transfer or from idle, at the falling edge
  always @(negedge clk_i) begin
    if (rst_ni && (!in_if.valid || in_taken)) begin
      in_taken = 1'b0;
      if (pending_items.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        in_if.data <= pending_items.pop_front();
        in_if.valid <= 1'b1;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted here
  always @(negedge clk_i) begin
    if (rx_hold_req) begin
      rx_hold_req = 1'b0;
      rx_hold_left = 300;
    end else if (rx_hold_left > 0) begin
      rx_hold_left--;
    end
  end

  always @(negedge clk_i) begin
    out_if.ready <= rst_ni && rx_hold_left == 0 && !rx_hold_req &&
                    $urandom_range(0, 99) >= rx_stall_pct;
  end

  // Monitor: predict on input transfer, check on output transfer
  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready) begin
      in_taken = 1'b1;
      if (in_if.data.func == FUNC_WRITE) begin
        perm_image[in_if.data.table_index] = in_if.data.table_value;
        writes_sent++;
      end else begin
        noise_expected.push_back(noise_at(in_if.data.x_coord, in_if.data.y_coord));
        evals_sent++;
      end
    end
    if (rst_ni && out_if.valid && out_if.ready) begin
      results_seen++;
      if (noise_expected.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result noise=%0d", out_if.data.noise_value);
      end else if (out_if.data.noise_value !== noise_expected[0]) begin
        errors++;
        if (errors <= 10)
          $display("mismatch result %0d: noise expected %0d got %0d", results_seen,
                   noise_expected[0], out_if.data.noise_value);
        void'(noise_expected.pop_front());
      end else begin
        void'(noise_expected.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", noise_expected.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    logic [7:0] perm_fill [256];
    int         swap_idx;
    logic [7:0] tmp;
    clk_i = 1'b0;
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_SKEW;
    cfg_data = '0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    errors = 0;
    evals_sent = 0;
    writes_sent = 0;
    results_seen = 0;
    cycle_count = 0;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    rx_hold_left = 0;
    rx_hold_req = 1'b0;
    in_taken = 1'b0;
    skew_shadow = SKEW_RESET;
    unskew_shadow = UNSKEW_RESET;
    foreach (perm_image[k]) perm_image[k] = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Load a shuffled permutation into every entry before any read
    foreach (perm_fill[k]) perm_fill[k] = 8'(k);
    for (int k = 255; k > 0; k--) begin
      swap_idx = $urandom_range(0, k);
      tmp = perm_fill[k];
      perm_fill[k] = perm_fill[swap_idx];
      perm_fill[swap_idx] = tmp;
    end
    foreach (perm_fill[k]) queue_write(8'(k), perm_fill[k]);

    // Directed: field extremes, corner choice, negative cells, wrap of hash
    queue_eval(32'h0000_0000, 32'h0000_0000);
    queue_eval(32'h7fff_ffff, 32'h7fff_ffff);
    queue_eval(32'h8000_0000, 32'h8000_0000);
    queue_eval(32'h7fff_ffff, 32'h8000_0000);
    queue_eval(32'h8000_0000, 32'h7fff_ffff);
    queue_eval(32'h0000_8000, 32'h0000_8000);
    queue_eval(32'h0000_c000, 32'h0000_4000);
    queue_eval(32'h0000_4000, 32'h0000_c000);
    queue_eval(32'hffff_8000, 32'hfffe_4000);
    queue_eval(32'h00ff_4321, 32'h00ff_9abc);
    queue_eval(32'h0000_0001, 32'hffff_ffff);
    queue_eval(32'h0000_5555, 32'h0000_5555);
    queue_write(8'hff, 8'hff);
    queue_write(8'h00, 8'h00);
    queue_eval(32'h00ff_8000, 32'h0000_2000);
    queue_eval(32'hffff_0000, 32'h00ff_ffff);

    // Phase 0: defaults, no idling
    queue_random(PHASE_ITEMS);
    drain();

    // Phase 1: zero registers, sender mostly idle
    write_cfg(CFG_SKEW, 16'h0000);
    write_cfg(CFG_UNSKEW, 16'h0000);
    tx_idle_pct = 82;
    queue_eval(32'h7fff_ffff, 32'h8000_0000);
    queue_random(PHASE_ITEMS);
    drain();

    // Phase 2: full-scale registers, receiver mostly stalled
    write_cfg(CFG_SKEW, 16'hffff);
    write_cfg(CFG_UNSKEW, 16'hffff);
    tx_idle_pct = 0;
    rx_stall_pct = 82;
    queue_eval(32'h7fff_ffff, 32'h7fff_ffff);
    queue_random(PHASE_ITEMS);
    drain();

    // Phase 3: random registers, both sides idle
    write_cfg(CFG_SKEW, 16'($urandom));
    write_cfg(CFG_UNSKEW, 16'($urandom));
    tx_idle_pct = 34;
    rx_stall_pct = 34;
    queue_random(PHASE_ITEMS);
    drain();

    // Phase 4: defaults again; long receiver hold-off fills the pipeline
    write_cfg(CFG_SKEW, SKEW_RESET);
    write_cfg(CFG_UNSKEW, UNSKEW_RESET);
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    queue_random(PHASE_ITEMS);
    repeat (30) @(posedge clk_i);
    rx_hold_req = 1'b1;
    drain();

    $display("covered %0d evaluations and %0d table writes, %0d results checked",
             evals_sent, writes_sent, results_seen);
    $display("register settings: reset, zero, full scale, random; idle and hold-off mixes");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches", errors);
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire
